// File: hw/rtl/jsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_pkg: shared types and constants of the joint speed command block
// Fixed-point formats, register indexes and the job record that travels from
// the classifier through the queue to the speed unit.
// ----------------------------------------------------------------------------
package jsc_pkg;

    // fixed-point format of angles and speeds
    localparam int FRAC_BITS  = 12;

    // joint counts
    localparam int NJ         = 6;
    localparam int NSCALE     = 5;

    // field widths
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = ANGLE_W + 1;
    localparam int MAG_W      = ANGLE_W;
    localparam int MAXS_W     = 15;
    localparam int DB_W       = 12;
    localparam int SPEED_W    = 19;

    // proportional gain and its product width
    localparam int GAIN       = 5;
    localparam int GAIN_W     = ERR_W + 3;

    // above this largest error the speeds are scaled instead of clamped
    localparam int unsigned SCALE_LIMIT = (314 << FRAC_BITS) / 100;

    // output saturation
    localparam int SPEED_MAX  = (1 << (SPEED_W - 1)) - 1;
    localparam int SPEED_MIN  = -(1 << (SPEED_W - 1));

    // scaled speed: |err| * max_speed / largest, largest above SCALE_LIMIT, so
    // joint 0..4 quotients stay below 2**QUOT_W; two quotient bits per cycle
    localparam int PROD_W     = MAG_W + MAXS_W;
    localparam int QUOT_W     = 18;
    localparam int ACC_W      = MAG_W + QUOT_W;
    localparam int DIV_CYCLES = QUOT_W / 2;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = CFG_IDX_W'(7);
    localparam logic [MAXS_W-1:0]    MAX_SPEED_RST = MAXS_W'(12861);
    localparam logic [DB_W-1:0]      DEADBAND_RST  = DB_W'(8);

    // queue between classifier and speed unit
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic signed [SPEED_W-1:0] speed_t;

    // one classified sample
    typedef struct packed {
        err_t [NJ-1:0]   err;
        logic [NJ-1:0]   active;
        logic            scale;
        mag_t            largest;
    } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/jsc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_if: channel interfaces of the joint speed command block
// Sample input, speed command output and configuration write channels, each
// a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------

// measured joint angles
interface jsc_in_if import jsc_pkg::*; ();
    logic   valid;
    logic   ready;
    angle_t actual_angle_0;
    angle_t actual_angle_1;
    angle_t actual_angle_2;
    angle_t actual_angle_3;
    angle_t actual_angle_4;
    angle_t actual_angle_5;

    modport source (
        output valid, actual_angle_0, actual_angle_1, actual_angle_2,
               actual_angle_3, actual_angle_4, actual_angle_5,
        input  ready
    );
    modport sink (
        input  valid, actual_angle_0, actual_angle_1, actual_angle_2,
               actual_angle_3, actual_angle_4, actual_angle_5,
        output ready
    );
endinterface

// joint speed commands
interface jsc_out_if import jsc_pkg::*; ();
    logic   valid;
    logic   ready;
    speed_t speed_0;
    speed_t speed_1;
    speed_t speed_2;
    speed_t speed_3;
    speed_t speed_4;
    speed_t speed_5;
    logic   at_goal;

    modport source (
        output valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
               at_goal,
        input  ready
    );
    modport sink (
        input  valid, speed_0, speed_1, speed_2, speed_3, speed_4, speed_5,
               at_goal,
        output ready
    );
endinterface

// register writes
interface jsc_cfg_if import jsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/joint_speed_command.sv
`default_nettype none
// ----------------------------------------------------------------------------
// joint_speed_command: six-joint speed command law
// Usage:
//   samples  - six measured joint angles, Q3.12 rad, valid/ready.
//   commands - six speed commands, Q6.12 rad/s, plus at_goal, valid/ready.
//   cfg      - register writes: index 0..5 goal angles, 6 max speed,
//              7 deadband. Write only while no sample is in flight.
// A sample whose largest error (joints 0..4) is within the limit has its
// commands pass the queue, the job register and the output register; a
// scaled sample also passes the multiply state and the divider of each
// joint, which retires two quotient bits per cycle. The speed unit takes
// one job at a time. A two-entry queue sits between the classifier and the
// speed unit, so samples are accepted while a result still waits in the
// output register. When the receiver stalls, the output register holds,
// the queue fills and samples.ready drops. Reset loads goals 0, max speed
// 12861, deadband 8, and empties the queue and output register; the block
// is ready at once.
// ----------------------------------------------------------------------------
module joint_speed_command import jsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    jsc_in_if.sink     samples,
    jsc_out_if.source  commands,
    jsc_cfg_if.sink    cfg
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    job_t              push_job;
    job_t              pop_job;
    logic [MAXS_W-1:0] max_speed;

    // classifier and register file
    jsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .max_speed (max_speed)
    );

    // job queue
    jsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // speed unit
    jsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .max_speed (max_speed),
        .commands  (commands)
    );

endmodule
`default_nettype wire

// File: hw/rtl/jsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_front: register file and sample classifier
// Holds the goal angles, speed limit and deadband. Each accepted sample is
// turned into joint errors, a deadband mask, the largest error over the
// scaled joints and the scale decision, and pushed into the queue.
// ----------------------------------------------------------------------------
module jsc_front import jsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    jsc_in_if.sink           samples,
    jsc_cfg_if.sink          cfg,
    input  wire logic        q_full,
    output logic             q_push,
    output job_t             q_job,
    output logic [MAXS_W-1:0] max_speed
);

    angle_t            goal_reg [NJ];
    logic [MAXS_W-1:0] max_speed_reg;
    logic [DB_W-1:0]   deadband_reg;

    angle_t actual [NJ];
    err_t   err    [NJ];
    mag_t   mag    [NJ];
    mag_t   largest;

    // register writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NJ; i++)
            begin
                goal_reg[i] <= '0;
            end
            max_speed_reg <= MAX_SPEED_RST;
            deadband_reg  <= DEADBAND_RST;
        end
        else if (cfg.valid)
        begin
            unique if (cfg.index < CFG_IDX_W'(NJ))
            begin
                goal_reg[cfg.index] <= cfg.data;
            end
            else if (cfg.index == REG_MAX_SPEED)
            begin
                max_speed_reg <= cfg.data[MAXS_W-1:0];
            end
            else if (cfg.index == REG_DEADBAND)
            begin
                deadband_reg <= cfg.data[DB_W-1:0];
            end
        end
    end

    assign max_speed = max_speed_reg;

    // sample fields
    assign actual[0] = samples.actual_angle_0;
    assign actual[1] = samples.actual_angle_1;
    assign actual[2] = samples.actual_angle_2;
    assign actual[3] = samples.actual_angle_3;
    assign actual[4] = samples.actual_angle_4;
    assign actual[5] = samples.actual_angle_5;

    // errors and magnitudes
    always_comb
    begin
        for (int i = 0; i < NJ; i++)
        begin
            err[i] = ERR_W'(goal_reg[i]) - ERR_W'(actual[i]);
            mag[i] = err[i][ERR_W-1] ? MAG_W'(-err[i]) : MAG_W'(err[i]);
        end
    end

    // largest magnitude over the scaled joints
    always_comb
    begin
        largest = '0;
        for (int i = 0; i < NSCALE; i++)
        begin
            if (mag[i] > largest)
            begin
                largest = mag[i];
            end
        end
    end

    // classified job
    always_comb
    begin
        for (int i = 0; i < NJ; i++)
        begin
            q_job.err[i]    = err[i];
            q_job.active[i] = mag[i] > MAG_W'(deadband_reg);
        end
        q_job.scale   = 32'(largest) > 32'(SCALE_LIMIT);
        q_job.largest = largest;
    end

    assign samples.ready = !q_full;
    assign q_push        = samples.valid && !q_full;

endmodule
`default_nettype wire

// File: hw/rtl/jsc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_queue: short job queue
// Two-entry FIFO between the classifier and the speed unit so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module jsc_queue import jsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/jsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsc_back: speed unit
// Takes one job at a time from the queue. Scaled jobs go through six
// multipliers and six radix-4 restoring dividers; clamped jobs go straight
// to the output stage. The result waits in an output register.
// ----------------------------------------------------------------------------
module jsc_back import jsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire job_t              q_job,
    output logic                   q_pop,
    input  wire logic [MAXS_W-1:0] max_speed,
    jsc_out_if.source              commands
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg,   state_next;
    logic [DCNT_W-1:0] cnt_reg,     cnt_next;
    logic              out_valid_reg;
    job_t              job_reg;
    logic [ACC_W-1:0]  acc_reg     [NJ];
    logic [ACC_W-1:0]  acc_next    [NJ];
    speed_t            speed_reg   [NJ];
    logic              at_goal_reg;

    mag_t              mag         [NJ];
    logic [PROD_W-1:0] prod        [NJ];
    speed_t            speed       [NJ];
    logic              out_load;

    // one restoring division step: acc holds remainder over quotient/dividend
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input mag_t d);
        logic [MAG_W:0]   t;
        logic [MAG_W-1:0] rem;
        logic             q_bit;
        t = {acc[ACC_W-1:QUOT_W], acc[QUOT_W-1]};
        if (t >= {1'b0, d})
        begin
            rem   = MAG_W'(t - {1'b0, d});
            q_bit = 1'b1;
        end
        else
        begin
            rem   = t[MAG_W-1:0];
            q_bit = 1'b0;
        end
        return {rem, acc[QUOT_W-2:0], q_bit};
    endfunction

    // products and division steps per lane
    always_comb
    begin
        for (int i = 0; i < NJ; i++)
        begin
            mag[i]  = job_reg.err[i][ERR_W-1] ? MAG_W'(-job_reg.err[i])
                                              : MAG_W'(job_reg.err[i]);
            prod[i] = PROD_W'(mag[i]) * PROD_W'(max_speed);
            if (state_reg == ST_MUL)
            begin
                acc_next[i] = ACC_W'(prod[i]);
            end
            else
            begin
                acc_next[i] = div_step(div_step(acc_reg[i], job_reg.largest),
                                       job_reg.largest);
            end
        end
    end

    // final speed per joint
    always_comb
    begin
        logic signed [GAIN_W-1:0] p;
        speed_t                   sq;
        for (int i = 0; i < NJ; i++)
        begin
            p  = GAIN_W'(job_reg.err[i]) * GAIN_W'(GAIN);
            sq = SPEED_W'(acc_reg[i][QUOT_W-1:0]);
            if (!job_reg.active[i])
            begin
                speed[i] = '0;
            end
            else if (job_reg.scale)
            begin
                speed[i] = job_reg.err[i][ERR_W-1] ? -sq : sq;
            end
            else
            begin
                if (p > signed'(GAIN_W'(max_speed)))
                begin
                    p = signed'(GAIN_W'(max_speed));
                end
                if (p < GAIN_W'(SPEED_MIN))
                begin
                    p = GAIN_W'(SPEED_MIN);
                end
                speed[i] = SPEED_W'(p);
            end
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || commands.ready);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_job.scale ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (commands.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job, division and output data
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (state_reg == ST_MUL || state_reg == ST_DIV)
        begin
            for (int i = 0; i < NJ; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
        if (out_load)
        begin
            for (int i = 0; i < NJ; i++)
            begin
                speed_reg[i] <= speed[i];
            end
            at_goal_reg <= ~|{speed[0], speed[1], speed[2],
                              speed[3], speed[4], speed[5]};
        end
    end

    assign commands.valid   = out_valid_reg;
    assign commands.speed_0 = speed_reg[0];
    assign commands.speed_1 = speed_reg[1];
    assign commands.speed_2 = speed_reg[2];
    assign commands.speed_3 = speed_reg[3];
    assign commands.speed_4 = speed_reg[4];
    assign commands.speed_5 = speed_reg[5];
    assign commands.at_goal = at_goal_reg;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for joint_speed_command
// Drives measured joint angles and register writes, predicts or looks up the
// six speed commands and the at_goal flag of every sample, and compares each
// command transaction with the oldest expected one. Directed rows come first,
// followed by random rounds under changing settings and handshake pressure.
// ----------------------------------------------------------------------------
module testbench;
    import jsc_pkg::*;

    // speed law constants, kept independent of the design's own
    localparam longint KP_GAIN         = 5;
    localparam longint ERR_SCALE_LIMIT = (314 << 12) / 100;
    localparam longint CMD_MAX         = 262143;
    localparam longint CMD_MIN         = -262144;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_0 = CFG_IDX_W'(0);

    // run control
    localparam int     ROUNDS          = 8;
    localparam int     ITEMS_PER_ROUND = 68;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint CYCLE_LIMIT     = 400000;

    typedef struct packed {
        speed_t [5:0] spd;
        logic         at_goal;
    } cmd_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        angle_t [5:0]         act;
        logic                 typed;
        cmd_t                 want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    jsc_in_if  sample_bus ();
    jsc_out_if command_bus ();
    jsc_cfg_if cfg_bus ();

    joint_speed_command u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_bus),
        .commands (command_bus),
        .cfg      (cfg_bus)
    );

    // predictor copy of the registers
    longint goal_q [6];
    longint max_speed_q;
    longint deadband_q;

    cmd_t     expected_cmds [$];
    dir_row_t dir_table [$];
    int       mismatches;
    int       src_idle_pct;
    int       snk_stall_pct;
    longint   cycle_count;
    cmd_t     seen_cmd;
    cmd_t     due_cmd;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // speed law: deadband, proportional with upper clamp, or scaled
    function automatic cmd_t predict_cmd(angle_t [5:0] act);
        cmd_t   r;
        longint e [6];
        longint m;
        longint largest;
        longint s;
        r = '0;
        r.at_goal = 1'b1;
        largest = 0;
        for (int j = 0; j < 6; j++)
            e[j] = goal_q[j] - longint'($signed(act[j]));
        // joint five stays out of the largest error
        for (int j = 0; j < 5; j++)
        begin
            m = (e[j] < 0) ? -e[j] : e[j];
            if (m > largest)
                largest = m;
        end
        for (int j = 0; j < 6; j++)
        begin
            s = 0;
            m = (e[j] < 0) ? -e[j] : e[j];
            if (m > deadband_q)
            begin
                if (largest > ERR_SCALE_LIMIT)
                    s = (e[j] * max_speed_q) / largest;
                else
                begin
                    s = e[j] * KP_GAIN;
                    if (s > max_speed_q)
                        s = max_speed_q;
                end
            end
            if (s > CMD_MAX)
                s = CMD_MAX;
            if (s < CMD_MIN)
                s = CMD_MIN;
            if (s != 0)
                r.at_goal = 1'b0;
            r.spd[j] = speed_t'(s);
        end
        return r;
    endfunction

    // directed table rows
    function automatic dir_row_t smp(int a0, int a1, int a2, int a3, int a4, int a5);
        dir_row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.act[0] = angle_t'(a0);
        r.act[1] = angle_t'(a1);
        r.act[2] = angle_t'(a2);
        r.act[3] = angle_t'(a3);
        r.act[4] = angle_t'(a4);
        r.act[5] = angle_t'(a5);
        return r;
    endfunction

    function automatic dir_row_t chk(dir_row_t r, int s0, int s1, int s2, int s3,
                                     int s4, int s5, logic g);
        dir_row_t t;
        t = r;
        t.typed = 1'b1;
        t.want.spd[0] = speed_t'(s0);
        t.want.spd[1] = speed_t'(s1);
        t.want.spd[2] = speed_t'(s2);
        t.want.spd[3] = speed_t'(s3);
        t.want.spd[4] = speed_t'(s4);
        t.want.spd[5] = speed_t'(s5);
        t.want.at_goal = g;
        return t;
    endfunction

    function automatic dir_row_t wr(logic [CFG_IDX_W-1:0] i, logic [15:0] d);
        dir_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = i;
        r.data = d;
        return r;
    endfunction

    // random sample: mostly near the goals so every branch of the law is hit
    function automatic angle_t [5:0] random_sample();
        angle_t [5:0] a;
        int profile;
        int mode;
        int r;
        int delta;
        profile = $urandom_range(99);
        for (int j = 0; j < 6; j++)
        begin
            if (profile < 10)
                mode = 3;
            else if (profile < 20)
                mode = 0;
            else
            begin
                mode = $urandom_range(9);
                mode = (mode < 3) ? 0 : (mode < 8) ? 1 : 2;
            end
            case (mode)
                0: r = int'(deadband_q) + 3;
                1: r = 2600;
                default: r = 14000;
            endcase
            delta = int'($urandom_range(2 * r)) - r;
            if (mode == 3)
                a[j] = angle_t'($urandom);
            else
                a[j] = angle_t'(goal_q[j] - delta);
        end
        return a;
    endfunction

    // one register write transaction; entered and left at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == REG_MAX_SPEED)
            max_speed_q = longint'(val[MAXS_W-1:0]);
        else if (idx == REG_DEADBAND)
            deadband_q = longint'(val[DB_W-1:0]);
        else
            goal_q[idx - REG_GOAL_0] = longint'($signed(val));
        @(negedge clk);
    endtask

    // one sample transaction with random idle cycles ahead of it
    task automatic send_sample(input angle_t [5:0] act, input logic typed, input cmd_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid = 1'b1;
        sample_bus.actual_angle_0 = act[0];
        sample_bus.actual_angle_1 = act[1];
        sample_bus.actual_angle_2 = act[2];
        sample_bus.actual_angle_3 = act[3];
        sample_bus.actual_angle_4 = act[4];
        sample_bus.actual_angle_5 = act[5];
        do
            @(posedge clk);
        while (!sample_bus.ready);
        expected_cmds.push_back(typed ? want : predict_cmd(act));
        @(negedge clk);
    endtask

    // let every pending command come out before touching the registers
    task automatic wait_drained();
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver backpressure
    always @(negedge clk)
        command_bus.ready <= ($urandom_range(99) >= snk_stall_pct);

    // command checker
    always @(posedge clk)
    begin
        if (rst_n && command_bus.valid && command_bus.ready)
        begin
            seen_cmd.spd[0]  = command_bus.speed_0;
            seen_cmd.spd[1]  = command_bus.speed_1;
            seen_cmd.spd[2]  = command_bus.speed_2;
            seen_cmd.spd[3]  = command_bus.speed_3;
            seen_cmd.spd[4]  = command_bus.speed_4;
            seen_cmd.spd[5]  = command_bus.speed_5;
            seen_cmd.at_goal = command_bus.at_goal;
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: command transaction with no sample pending, speed_0 %0d",
                         $time, $signed(seen_cmd.spd[0]));
            end
            else
            begin
                due_cmd = expected_cmds.pop_front();
                for (int j = 0; j < 6; j++)
                begin
                    if (seen_cmd.spd[j] !== due_cmd.spd[j])
                    begin
                        mismatches++;
                        $display("%0t: speed_%0d expected %0d, actual %0d", $time, j,
                                 $signed(due_cmd.spd[j]), $signed(seen_cmd.spd[j]));
                    end
                end
                if (seen_cmd.at_goal !== due_cmd.at_goal)
                begin
                    mismatches++;
                    $display("%0t: at_goal expected %0b, actual %0b", $time,
                             due_cmd.at_goal, seen_cmd.at_goal);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("joint_speed_command: mismatch");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        sample_bus.valid = 1'b0;
        sample_bus.actual_angle_0 = '0;
        sample_bus.actual_angle_1 = '0;
        sample_bus.actual_angle_2 = '0;
        sample_bus.actual_angle_3 = '0;
        sample_bus.actual_angle_4 = '0;
        sample_bus.actual_angle_5 = '0;
        command_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        for (int j = 0; j < 6; j++)
            goal_q[j] = 0;
        max_speed_q = 12861;
        deadband_q = 8;

        // directed table, starting from the reset settings
        dir_table.push_back(chk(smp(0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 1'b1));
        // deadband edge: equal stays quiet, one more moves
        dir_table.push_back(chk(smp(-8, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 1'b1));
        dir_table.push_back(chk(smp(-9, 0, 0, 0, 0, 0), 45, 0, 0, 0, 0, 0, 1'b0));
        dir_table.push_back(chk(smp(9, 0, 0, 0, 0, 0), -45, 0, 0, 0, 0, 0, 1'b0));
        // upper clamp only
        dir_table.push_back(chk(smp(0, -3000, 0, 0, 0, 0), 0, 12861, 0, 0, 0, 0, 1'b0));
        dir_table.push_back(chk(smp(0, 0, 3000, 0, 0, 0), 0, 0, -15000, 0, 0, 0, 1'b0));
        // largest error at the limit, then just above it
        dir_table.push_back(chk(smp(0, 0, 0, -12861, 0, 0), 0, 0, 0, 12861, 0, 0, 1'b0));
        dir_table.push_back(chk(smp(0, 0, 0, 0, -12862, 0), 0, 0, 0, 0, 12861, 0, 1'b0));
        dir_table.push_back(chk(smp(32767, 0, 0, 0, 0, 0), -12861, 0, 0, 0, 0, 0, 1'b0));
        dir_table.push_back(chk(smp(-32768, 0, 0, 0, 0, 0), 12861, 0, 0, 0, 0, 0, 1'b0));
        // joint five scaled past max speed
        dir_table.push_back(smp(-16384, 0, 0, 0, 0, 32767));
        // joint five alone never triggers scaling
        dir_table.push_back(chk(smp(0, 0, 0, 0, 0, -32768), 0, 0, 0, 0, 0, 12861, 1'b0));
        dir_table.push_back(chk(smp(0, 0, 0, 0, 0, 32767), 0, 0, 0, 0, 0, -163835, 1'b0));
        dir_table.push_back(smp(-1000, 2000, -50, 60, -4, 4));
        // output saturation on joint five
        dir_table.push_back(wr(REG_GOAL_0 + 3'd5, 16'h8000));
        dir_table.push_back(chk(smp(0, 0, 0, 0, 0, 32767), 0, 0, 0, 0, 0, -262144, 1'b0));
        dir_table.push_back(chk(smp(0, 0, 0, 0, 0, -32768), 0, 0, 0, 0, 0, 0, 1'b1));
        // zero max speed: clamped and scaled speeds vanish
        dir_table.push_back(wr(REG_MAX_SPEED, 16'h0000));
        dir_table.push_back(chk(smp(-100, 0, 0, 0, 0, -32768), 0, 0, 0, 0, 0, 0, 1'b1));
        dir_table.push_back(chk(smp(-20000, 0, 0, 0, 0, -32768), 0, 0, 0, 0, 0, 0, 1'b1));
        // full max speed, no deadband
        dir_table.push_back(wr(REG_MAX_SPEED, 16'h7fff));
        dir_table.push_back(wr(REG_DEADBAND, 16'h0000));
        dir_table.push_back(chk(smp(-1, 0, 0, 0, 0, -32768), 5, 0, 0, 0, 0, 0, 1'b0));
        dir_table.push_back(chk(smp(-7000, 0, 0, 0, 0, -32768), 32767, 0, 0, 0, 0, 0, 1'b0));
        dir_table.push_back(smp(-32768, 0, 0, 0, 0, 32767));
        // widest deadband
        dir_table.push_back(wr(REG_DEADBAND, 16'h0fff));
        dir_table.push_back(chk(smp(-4095, 0, 0, 0, 0, -32768), 0, 0, 0, 0, 0, 0, 1'b1));
        dir_table.push_back(chk(smp(-4096, 0, 0, 0, 0, -32768), 20480, 0, 0, 0, 0, 0, 1'b0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_WRITE)
            begin
                sample_bus.valid = 1'b0;
                wait_drained();
                write_reg(dir_table[i].idx, dir_table[i].data);
                cfg_bus.valid = 1'b0;
            end
            else
                send_sample(dir_table[i].act, dir_table[i].typed, dir_table[i].want);
        end

        // random rounds, each under fresh settings and handshake pressure
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            sample_bus.valid = 1'b0;
            wait_drained();
            for (int j = 0; j < 6; j++)
            begin
                case (rnd)
                    3: write_reg(REG_GOAL_0 + CFG_IDX_W'(j), 16'h8000);
                    4: write_reg(REG_GOAL_0 + CFG_IDX_W'(j), 16'h7fff);
                    default: write_reg(REG_GOAL_0 + CFG_IDX_W'(j), 16'($urandom));
                endcase
            end
            // unused upper data bits carry noise
            case (rnd)
                0: write_reg(REG_MAX_SPEED, {1'($urandom), 15'd12861});
                1: write_reg(REG_MAX_SPEED, {1'($urandom), 15'd0});
                2, 3: write_reg(REG_MAX_SPEED, {1'($urandom), 15'h7fff});
                default: write_reg(REG_MAX_SPEED, 16'($urandom));
            endcase
            case (rnd)
                1, 3: write_reg(REG_DEADBAND, {4'($urandom), 12'd0});
                2: write_reg(REG_DEADBAND, {4'($urandom), 12'hfff});
                default:
                    if ($urandom_range(3) == 0)
                        write_reg(REG_DEADBAND, 16'($urandom));
                    else
                        write_reg(REG_DEADBAND, {4'($urandom), 12'($urandom_range(64))});
            endcase
            cfg_bus.valid = 1'b0;

            case (rnd % 4)
                0:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 85;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 85;
                end
                default:
                begin
                    src_idle_pct = 24;
                    snk_stall_pct = 24;
                end
            endcase

            repeat (ITEMS_PER_ROUND) send_sample(random_sample(), 1'b0, '0);
        end
        sample_bus.valid = 1'b0;

        // drain and report
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("joint_speed_command: match");
        else
            $display("joint_speed_command: mismatch");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/jsc_pkg.sv
hw/rtl/jsc_if.sv
hw/rtl/jsc_front.sv
hw/rtl/jsc_queue.sv
hw/rtl/jsc_back.sv
hw/rtl/joint_speed_command.sv
test/testbench.sv
